FILE: hw/rtl/stt_pkg.sv
// Shared types, constants and keyword tables for the source text tokenizer.
// Used by stt_ctrl, stt_datapath and source_text_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int unsigned MAX_TEXT = 32;
    localparam int unsigned TXT_AW   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int unsigned LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int unsigned NUM_W    = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    localparam int unsigned KW_COUNT   = 10;
    localparam int unsigned KW_MAX_LEN = 6;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"s", "t", "r", "i", "n", "g"},
        '{"p", "r", "i", "n", "t", 8'h00},
        '{"a", "s", "k", 8'h00, 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00}
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{3, 4, 5, 6, 5, 3, 4, 4, 5, 3};

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_KEYWORD = 4'd1,
        KIND_NUMBER  = 4'd2,
        KIND_STRING  = 4'd3,
        KIND_CHAR    = 4'd4,
        KIND_OPER    = 4'd5,
        KIND_SEMI    = 4'd6,
        KIND_UNKNOWN = 4'd7,
        KIND_BADCHAR = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        SRC_TEXT,
        SRC_EMPTY,
        SRC_NUM,
        SRC_HELD,
        SRC_BYTE
    } src_t;

    typedef struct packed {
        logic ws;
        logic word_start;
        logic digit;
        logic ident;
        logic dquote;
        logic squote;
        logic emits;
    } byte_class_t;

    typedef struct packed {
        logic  latch_in;
        logic  start_text;
        logic  append;
        logic  num_start;
        logic  num_step;
        logic  hold_char;
        logic  rd_en;
        logic  idx_clr;
        logic  idx_inc;
        logic  load_out;
        src_t  out_sel;
        kind_t out_kind;
        logic  out_end;
        logic  out_done;
    } ctrl_cmd_t;

    typedef struct packed {
        byte_class_t cls;
        logic        flush;
        logic        out_free;
        logic        text_empty;
        logic        text_last;
        logic        kw_hit;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stt_datapath.sv
// Tokenizer datapath: input word register, text buffer, keyword match,
// number accumulator and output word register. Depends on stt_pkg and stt_ram.
`timescale 1ns / 1ps
`default_nettype none

module stt_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               operation,
    input  wire logic [7:0]         source_byte,
    input  wire stt_pkg::ctrl_cmd_t cmd,
    output stt_pkg::dp_stat_t       stat,
    input  wire logic               token_ready,
    output logic                    token_valid,
    output logic [3:0]              kind,
    output logic [7:0]              text_byte,
    output logic [30:0]             number_value,
    output logic                    token_end,
    output logic                    input_done,
    output logic                    empty_text,
    output logic                    truncated
);

    import stt_pkg::*;

    logic              op_reg;
    logic [7:0]        byte_reg;
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic              ovf_reg,  ovf_next;
    logic [KW_COUNT-1:0] match_reg, match_next;
    logic [NUM_W-1:0]  acc_reg,  acc_next;
    logic [7:0]        held_reg, held_next;
    logic [TXT_AW-1:0] idx_reg,  idx_next;
    logic              valid_reg, valid_next;

    kind_t             kind_reg;
    logic [7:0]        tbyte_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              end_reg;
    logic              done_reg;
    logic              empty_reg;
    logic              trunc_reg;

    logic [LEN_W-1:0]    base_len;
    logic [KW_COUNT-1:0] base_match;
    logic [KW_COUNT-1:0] kw_step;
    logic                base_ovf;
    logic                wr_en;
    logic [7:0]          rd_data;
    logic [NUM_W+3:0]    num_prod;
    logic [3:0]          digit_val;
    byte_class_t         cls;
    kind_t               byte_kind;
    logic                is_alpha;
    logic                is_oper;
    logic                kw_hit;

    stt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base_len[TXT_AW-1:0]),
        .wr_data (byte_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        is_alpha = (byte_reg >= "a" && byte_reg <= "z") || (byte_reg >= "A" && byte_reg <= "Z");
        is_oper  = (byte_reg == "+") || (byte_reg == "-") || (byte_reg == "*") ||
                   (byte_reg == "/") || (byte_reg == "=") || (byte_reg == "(") ||
                   (byte_reg == ")") || (byte_reg == ",");
        cls.ws         = (byte_reg == CH_SPACE) || (byte_reg >= CH_TAB && byte_reg <= CH_CR);
        cls.word_start = is_alpha || (byte_reg == CH_UNDER);
        cls.digit      = (byte_reg >= "0") && (byte_reg <= "9");
        cls.ident      = cls.word_start || cls.digit;
        cls.dquote     = (byte_reg == CH_DQUOTE);
        cls.squote     = (byte_reg == CH_SQUOTE);
        cls.emits      = !(cls.ws || cls.ident || cls.dquote || cls.squote);
        if (is_oper)
        begin
            byte_kind = KIND_OPER;
        end
        else if (byte_reg == CH_SEMI)
        begin
            byte_kind = KIND_SEMI;
        end
        else
        begin
            byte_kind = KIND_UNKNOWN;
        end
    end

    always_comb
    begin
        kw_hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (match_reg[k] && (len_reg == LEN_W'(KW_LEN[k])))
            begin
                kw_hit = 1'b1;
            end
        end
        kw_hit = kw_hit && !ovf_reg;
    end

    always_comb
    begin
        stat.cls        = cls;
        stat.flush      = (op_reg == OP_FLUSH);
        stat.out_free   = !valid_reg || token_ready;
        stat.text_empty = (len_reg == '0);
        stat.text_last  = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
        stat.kw_hit     = kw_hit;
    end

    always_comb
    begin
        base_len   = cmd.start_text ? '0 : len_reg;
        base_match = cmd.start_text ? '1 : match_reg;
        base_ovf   = cmd.start_text ? 1'b0 : ovf_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_step[k] = 1'b0;
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (base_len == LEN_W'(j))
                begin
                    kw_step[k] = (j < KW_LEN[k]) && (KW_TEXT[k][j] == byte_reg);
                end
            end
        end

        digit_val = 4'(byte_reg - CH_ZERO);
        num_prod  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (NUM_W+4)'(digit_val);

        wr_en      = 1'b0;
        len_next   = base_len;
        match_next = base_match;
        ovf_next   = base_ovf;
        acc_next   = acc_reg;
        held_next  = held_reg;
        idx_next   = idx_reg;

        if (cmd.append)
        begin
            if (base_len < LEN_W'(MAX_TEXT))
            begin
                wr_en      = 1'b1;
                len_next   = base_len + LEN_W'(1);
                match_next = base_match & kw_step;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.num_start)
        begin
            acc_next = NUM_W'(digit_val);
            ovf_next = 1'b0;
        end
        if (cmd.num_step)
        begin
            if (num_prod > (NUM_W+4)'(NUM_MAX))
            begin
                acc_next = NUM_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = num_prod[NUM_W-1:0];
            end
        end
        if (cmd.hold_char)
        begin
            held_next = byte_reg;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + TXT_AW'(1);
        end

        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (token_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            match_reg <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            match_reg <= match_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= operation;
            byte_reg <= source_byte;
        end
        if (cmd.load_out)
        begin
            kind_reg  <= (cmd.out_sel == SRC_BYTE) ? byte_kind : cmd.out_kind;
            end_reg   <= cmd.out_end;
            done_reg  <= cmd.out_done;
            empty_reg <= (cmd.out_sel == SRC_EMPTY);
            num_reg   <= (cmd.out_sel == SRC_NUM) ? acc_reg : '0;
            trunc_reg <= ((cmd.out_sel == SRC_TEXT) || (cmd.out_sel == SRC_EMPTY) ||
                          (cmd.out_sel == SRC_NUM)) && ovf_reg;
            case (cmd.out_sel)
                SRC_TEXT: tbyte_reg <= rd_data;
                SRC_HELD: tbyte_reg <= held_reg;
                SRC_BYTE: tbyte_reg <= byte_reg;
                default:  tbyte_reg <= 8'h00;
            endcase
        end
    end

    assign token_valid  = valid_reg;
    assign kind         = kind_reg;
    assign text_byte    = tbyte_reg;
    assign number_value = num_reg;
    assign token_end    = end_reg;
    assign input_done   = done_reg;
    assign empty_text   = empty_reg;
    assign truncated    = trunc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/stt_ctrl.sv
// Tokenizer controller: scan mode and the sequencer that accepts words and
// plays out token text. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              source_valid,
    output logic                   source_ready,
    input  wire stt_pkg::dp_stat_t stat,
    output stt_pkg::ctrl_cmd_t     cmd
);

    import stt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HANDLE,
        S_SINGLE,
        S_TXT_RD,
        S_TXT_WR
    } state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUM,
        M_STR,
        M_QOPEN,
        M_QHELD
    } mode_t;

    state_t state_reg,  state_next;
    mode_t  mode_reg,   mode_next;
    logic   follow_reg, follow_next;
    src_t   sel_reg,    sel_next;
    kind_t  kind_reg,   kind_next;

    logic   go_text;
    logic   go_single;
    logic   follow_set;
    kind_t  txt_kind;
    kind_t  one_kind;
    src_t   one_sel;
    kind_t  word_kind;

    assign source_ready = (state_reg == S_IDLE);
    assign word_kind    = stat.kw_hit ? KIND_KEYWORD : KIND_IDENT;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        follow_next = follow_reg;
        sel_next    = sel_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        go_text     = 1'b0;
        go_single   = 1'b0;
        follow_set  = 1'b0;
        txt_kind    = KIND_IDENT;
        one_kind    = KIND_NUMBER;
        one_sel     = SRC_NUM;

        case (state_reg)
            S_IDLE:
            begin
                if (source_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.flush)
                begin
                    mode_next  = M_IDLE;
                    state_next = S_IDLE;
                    case (mode_reg)
                        M_IDENT:
                        begin
                            go_text  = 1'b1;
                            txt_kind = word_kind;
                        end
                        M_NUM:
                        begin
                            go_single = 1'b1;
                        end
                        M_STR:
                        begin
                            go_text  = 1'b1;
                            txt_kind = KIND_STRING;
                        end
                        M_QHELD:
                        begin
                            go_single = 1'b1;
                            one_sel   = SRC_HELD;
                            one_kind  = KIND_BADCHAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    case (mode_reg)
                        M_IDENT:
                        begin
                            if (stat.cls.ident)
                            begin
                                cmd.append = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                go_text    = 1'b1;
                                txt_kind   = word_kind;
                                follow_set = 1'b1;
                                mode_next  = M_IDLE;
                            end
                        end
                        M_NUM:
                        begin
                            if (stat.cls.digit)
                            begin
                                cmd.num_step = 1'b1;
                                state_next   = S_IDLE;
                            end
                            else
                            begin
                                go_single  = 1'b1;
                                follow_set = 1'b1;
                                mode_next  = M_IDLE;
                            end
                        end
                        M_STR:
                        begin
                            if (stat.cls.dquote)
                            begin
                                go_text   = 1'b1;
                                txt_kind  = KIND_STRING;
                                mode_next = M_IDLE;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        M_QOPEN:
                        begin
                            cmd.hold_char = 1'b1;
                            mode_next     = M_QHELD;
                            state_next    = S_IDLE;
                        end
                        M_QHELD:
                        begin
                            mode_next = M_IDLE;
                            go_single = 1'b1;
                            one_sel   = SRC_HELD;
                            if (stat.cls.squote)
                            begin
                                one_kind = KIND_CHAR;
                            end
                            else
                            begin
                                one_kind   = KIND_BADCHAR;
                                follow_set = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_HANDLE;
                        end
                    endcase
                end
            end
            S_HANDLE:
            begin
                if (stat.cls.emits)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = SRC_BYTE;
                        cmd.out_end  = 1'b1;
                        cmd.out_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                    if (stat.cls.word_start)
                    begin
                        mode_next      = M_IDENT;
                        cmd.start_text = 1'b1;
                        cmd.append     = 1'b1;
                    end
                    else if (stat.cls.digit)
                    begin
                        mode_next     = M_NUM;
                        cmd.num_start = 1'b1;
                    end
                    else if (stat.cls.dquote)
                    begin
                        mode_next      = M_STR;
                        cmd.start_text = 1'b1;
                    end
                    else if (stat.cls.squote)
                    begin
                        mode_next = M_QOPEN;
                    end
                end
            end
            S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = sel_reg;
                    cmd.out_kind = kind_reg;
                    cmd.out_end  = 1'b1;
                    cmd.out_done = !follow_reg || !stat.cls.emits;
                    state_next   = follow_reg ? S_HANDLE : S_IDLE;
                end
            end
            S_TXT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_TXT_WR;
            end
            S_TXT_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = SRC_TEXT;
                    cmd.out_kind = kind_reg;
                    cmd.out_end  = stat.text_last;
                    cmd.out_done = stat.text_last && (!follow_reg || !stat.cls.emits);
                    cmd.idx_inc  = 1'b1;
                    if (stat.text_last)
                    begin
                        state_next = follow_reg ? S_HANDLE : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TXT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_text)
        begin
            cmd.idx_clr = 1'b1;
            kind_next   = txt_kind;
            follow_next = follow_set;
            if (stat.text_empty)
            begin
                sel_next   = SRC_EMPTY;
                state_next = S_SINGLE;
            end
            else
            begin
                state_next = S_TXT_RD;
            end
        end
        if (go_single)
        begin
            sel_next    = one_sel;
            kind_next   = one_kind;
            follow_next = follow_set;
            state_next  = S_SINGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= M_IDLE;
            follow_reg <= 1'b0;
            sel_reg    <= SRC_NUM;
            kind_reg   <= KIND_IDENT;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            follow_reg <= follow_next;
            sel_reg    <= sel_next;
            kind_reg   <= kind_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer: controller plus datapath.
// Depends on stt_pkg, stt_ctrl, stt_datapath and stt_ram.
//
//   Channel  Handshake                    Word contents
//   source   source_valid / source_ready  operation, source_byte
//   token    token_valid / token_ready    kind, text_byte, number_value, token_end,
//                                         input_done, empty_text, truncated
//
// A word that extends a token, or a flush with nothing pending, goes from the decide step
// back to idle; a word that an idle scanner classifies passes through the handle step too.
// Closing a token plays out a word per text byte, read from the text RAM, or a single word
// for a number, char literal or empty string; a handled closing byte is dealt with after it.
// Reset is asynchronous and needs no clearing pass; the text RAM is read only where written.
// A stalled token port holds the sequencer in its output step until the word is taken.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        source_valid,
    output logic             source_ready,
    input  wire logic        operation,
    input  wire logic [7:0]  source_byte,
    output logic             token_valid,
    input  wire logic        token_ready,
    output logic [3:0]       kind,
    output logic [7:0]       text_byte,
    output logic [30:0]      number_value,
    output logic             token_end,
    output logic             input_done,
    output logic             empty_text,
    output logic             truncated
);

    import stt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    stt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_ready (source_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    stt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .source_byte  (source_byte),
        .cmd          (cmd),
        .stat         (stat),
        .token_ready  (token_ready),
        .token_valid  (token_valid),
        .kind         (kind),
        .text_byte    (text_byte),
        .number_value (number_value),
        .token_end    (token_end),
        .input_done   (input_done),
        .empty_text   (empty_text),
        .truncated    (truncated)
    );

endmodule

`default_nettype wire
